// ----- sv/euq_pkg.sv -----
// Shared types and constants for the Euler angle to quaternion converter.
package euq_pkg;

  localparam int WB = 34;

  localparam logic signed [WB-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [WB-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [WB-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [WB-1:0] x;
    logic signed [WB-1:0] y;
    logic signed [WB-1:0] z;
    logic                 neg;
  } cordic_lane_t;

  typedef cordic_lane_t [2:0] lane_set_t;

endpackage

// ----- sv/euq_prep.sv -----
// Input stage: angle scaling to Q30 and quadrant fold into the CORDIC range.
module euq_prep import euq_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [47:0] in_data,
  output logic        valid_r,
  output lane_set_t   lanes_r
);

  localparam int SH = 32 - ANGLE_BITS;

  lane_set_t lanes_nxt;

  always_comb begin
    logic [31:0]                   raw;
    logic signed [ANGLE_BITS-1:0]  a;
    logic signed [WB-1:0]          h;
    for (int i = 0; i < 3; i++) begin
      raw = {16'b0, in_data[16*i +: 16]};
      a   = raw[ANGLE_BITS-1:0];
      h   = WB'(a) <<< SH;
      lanes_nxt[i].x   = Q30_GAIN;
      lanes_nxt[i].y   = '0;
      lanes_nxt[i].neg = 1'b0;
      lanes_nxt[i].z   = h;
      if (h > Q30_HALF_PI) begin
        lanes_nxt[i].z   = h - Q30_PI;
        lanes_nxt[i].neg = 1'b1;
      end else if (h < -Q30_HALF_PI) begin
        lanes_nxt[i].z   = h + Q30_PI;
        lanes_nxt[i].neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

// ----- sv/euq_cordic_cell.sv -----
// One CORDIC rotation step for the three angle lanes.
module euq_cordic_cell import euq_pkg::*; #(
  parameter int K = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      valid_in,
  input  lane_set_t lanes_in,
  output logic      valid_r,
  output lane_set_t lanes_r
);

  localparam logic signed [WB-1:0] DA = WB'(signed'({1'b0, ATAN_Q30[K]}));

  lane_set_t lanes_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lanes_nxt[i].neg = lanes_in[i].neg;
      if (!lanes_in[i].z[WB-1]) begin
        lanes_nxt[i].x = lanes_in[i].x - (lanes_in[i].y >>> K);
        lanes_nxt[i].y = lanes_in[i].y + (lanes_in[i].x >>> K);
        lanes_nxt[i].z = lanes_in[i].z - DA;
      end else begin
        lanes_nxt[i].x = lanes_in[i].x + (lanes_in[i].y >>> K);
        lanes_nxt[i].y = lanes_in[i].y - (lanes_in[i].x >>> K);
        lanes_nxt[i].z = lanes_in[i].z + DA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
    if (adv) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

// ----- sv/euq_combine.sv -----
// Quaternion assembly: pair products, triple products, sums, rounding, saturation.
module euq_combine import euq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        direction,
  input  logic        valid_in,
  input  lane_set_t   lanes_in,
  output logic        valid_r,
  output logic [63:0] data_r
);

  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs[i] = lanes_in[i].neg ? 32'(-lanes_in[i].x) : 32'(lanes_in[i].x);
      sn[i] = lanes_in[i].neg ? 32'(-lanes_in[i].y) : 32'(lanes_in[i].y);
    end
  end

  // pair products: chcp, shsp, chsp, shcp
  logic signed [33:0] p_r [4];
  logic signed [31:0] sb_r, cb_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_in;
    end
    if (adv) begin
      p_r[0] <= 34'((64'(cs[0]) * 64'(cs[1])) >>> 30);
      p_r[1] <= 34'((64'(sn[0]) * 64'(sn[1])) >>> 30);
      p_r[2] <= 34'((64'(cs[0]) * 64'(sn[1])) >>> 30);
      p_r[3] <= 34'((64'(sn[0]) * 64'(cs[1])) >>> 30);
      sb_r   <= sn[2];
      cb_r   <= cs[2];
    end
  end

  // triple products: w0 w1 x0 x1 y0 y1 z0 z1
  logic signed [35:0] t_r [8];
  logic               v2_r;

  function automatic logic signed [35:0] mul_t(logic signed [33:0] a, logic signed [31:0] b);
    logic signed [65:0] m;
    m = 66'(a) * 66'(b);
    return 36'(m >>> 30);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      t_r[0] <= mul_t(p_r[0], cb_r);
      t_r[1] <= mul_t(p_r[1], sb_r);
      t_r[2] <= mul_t(p_r[2], cb_r);
      t_r[3] <= mul_t(p_r[3], sb_r);
      t_r[4] <= mul_t(p_r[3], cb_r);
      t_r[5] <= mul_t(p_r[2], sb_r);
      t_r[6] <= mul_t(p_r[0], sb_r);
      t_r[7] <= mul_t(p_r[1], cb_r);
    end
  end

  function automatic logic [15:0] to_q14(logic signed [37:0] v);
    logic signed [37:0] r;
    r = (v + 38'sd32768) >>> 16;
    if (r > 38'sd32767) return 16'h7FFF;
    if (r < -38'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  logic signed [37:0] w, x, y, z;
  logic [63:0]        data_nxt;

  always_comb begin
    w = 38'(t_r[0]) + 38'(t_r[1]);
    x = 38'(t_r[2]) + 38'(t_r[3]);
    y = 38'(t_r[4]) - 38'(t_r[5]);
    z = 38'(t_r[6]) - 38'(t_r[7]);
    if (!direction) begin
      x = -x;
      y = -y;
      z = -z;
    end
    data_nxt = {to_q14(z), to_q14(y), to_q14(x), to_q14(w)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= v2_r;
    end
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/euler_to_quaternion.sv -----
// Top level: Euler angle triple to quaternion converter, one beat per cycle.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------
//  in      | in_tvalid in_tready in_tdata   | heading, pitch, bank (Q2.13 each)
//  out     | out_tvalid out_tready out_tdata| w, x, y, z (Q1.14 each)
//  cfg     | cfg_valid cfg_ready cfg_data   | direction bit
//
// One beat enters per cycle unless the output stalls; each beat passes through
// the fold stage, the CORDIC cell row, two multiplier stages and the output stage.
// Reset clears all valid bits and sets direction to inertial-to-object.
// A stalled output freezes the whole pipeline; in_tready drops only then.
module euler_to_quaternion import euq_pkg::*; #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // heading_angle, pitch_angle, bank_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // comp_w, comp_x, comp_y, comp_z
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic      adv;
  logic      direction_r;
  logic      v_chain [CORDIC_STAGES+1];
  lane_set_t l_chain [CORDIC_STAGES+1];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_valid) begin
      direction_r <= cfg_data;
    end
  end

  euq_prep #(.ANGLE_BITS(ANGLE_BITS)) u_prep (
    .clk, .rst_n, .adv,
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .valid_r  (v_chain[0]),
    .lanes_r  (l_chain[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    euq_cordic_cell #(.K(k)) u_cell (
      .clk, .rst_n, .adv,
      .valid_in (v_chain[k]),
      .lanes_in (l_chain[k]),
      .valid_r  (v_chain[k+1]),
      .lanes_r  (l_chain[k+1])
    );
  end

  euq_combine u_comb (
    .clk, .rst_n, .adv,
    .direction (direction_r),
    .valid_in  (v_chain[CORDIC_STAGES]),
    .lanes_in  (l_chain[CORDIC_STAGES]),
    .valid_r   (out_tvalid),
    .data_r    (out_tdata)
  );

endmodule

// ----- sv/euq_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module euq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind euler_to_quaternion euq_checker u_euq_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_ready
);

// ----- verif/tb_top.sv -----
// Testbench for the Euler angle to quaternion converter: scoreboarded random streaming.
`timescale 1ns / 1ps

class quat_scoreboard;
  logic [63:0] pending_quats[$];
  bit          dir;
  int          errors;
  int          checked;

  function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function void half_sin_cos(logic [15:0] raw, output longint s, output longint c);
    longint h, x, y, z, dx, dy, da;
    bit     neg;
    h = longint'($signed(raw)) * 65536;
    x = longint'(euq_pkg::Q30_GAIN);
    y = 0;
    neg = 0;
    if (h > longint'(euq_pkg::Q30_HALF_PI)) begin
      h -= longint'(euq_pkg::Q30_PI);
      neg = 1;
    end else if (h < -longint'(euq_pkg::Q30_HALF_PI)) begin
      h += longint'(euq_pkg::Q30_PI);
      neg = 1;
    end
    z = h;
    for (int k = 0; k < 16; k++) begin
      dx = floor_shift(y, k);
      dy = floor_shift(x, k);
      da = longint'(euq_pkg::ATAN_Q30[k]);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= da;
      end else begin
        x += dx;
        y -= dy;
        z += da;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function longint prod3(longint a, longint b, longint c);
    return floor_shift(floor_shift(a * b, 30) * c, 30);
  endfunction

  function logic [15:0] to_q14(longint v);
    longint r;
    r = floor_shift(v + 32768, 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function void note_angles(logic [47:0] beat);
    longint sh, ch, sp, cp, sb, cb, w, x, y, z;
    half_sin_cos(beat[15:0], sh, ch);
    half_sin_cos(beat[31:16], sp, cp);
    half_sin_cos(beat[47:32], sb, cb);
    w = prod3(ch, cp, cb) + prod3(sh, sp, sb);
    x = prod3(ch, sp, cb) + prod3(sh, cp, sb);
    y = prod3(sh, cp, cb) - prod3(ch, sp, sb);
    z = prod3(ch, cp, sb) - prod3(sh, sp, cb);
    if (!dir) begin
      x = -x;
      y = -y;
      z = -z;
    end
    pending_quats.push_back({to_q14(z), to_q14(y), to_q14(x), to_q14(w)});
  endfunction

  function void check_quat(logic [63:0] got);
    logic [63:0] exp_q;
    checked++;
    if (pending_quats.size() == 0) begin
      $display("%0t: unexpected beat %h", $time, got);
      errors++;
      return;
    end
    exp_q = pending_quats.pop_front();
    for (int f = 0; f < 4; f++)
      if (exp_q[16*f +: 16] !== got[16*f +: 16]) begin
        $display("%0t: component %0d expected %h actual %h", $time, f,
                 exp_q[16*f +: 16], got[16*f +: 16]);
        errors++;
      end
  endfunction
endclass

module tb_top;
  import euq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  quat_scoreboard quat_sb;
  int  send_idle_pct;
  int  stall_pct;
  int  hold_off;
  int  quiet_cycles;
  int  beats_in;

  euler_to_quaternion dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) quat_sb.check_quat(out_tdata);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function logic [15:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(25736 + $urandom_range(4) - 2);  // near +pi/2 fold
      4: return 16'(-25736 + $urandom_range(4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_angles(logic [47:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_sb.note_angles(beat);
    beats_in++;
  endtask

  task automatic write_direction(bit d);
    in_tvalid <= 1'b0;
    while (quat_sb.pending_quats.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    quat_sb.dir = d;
  endtask

  initial begin
    logic [15:0] corners[6];
    quat_sb = new();
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h6488};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_data = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    quiet_cycles = 0;
    beats_in = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int d = 0; d < 2; d++) begin
      write_direction(d[0]);
      for (int i = 0; i < 12; i++)
        send_angles({corners[(i + 2) % 6], corners[(i / 2) % 6], corners[i % 6]});
    end
    for (int phase = 0; phase < 8; phase++) begin
      write_direction(phase[0] ^ phase[2]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        3: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      if (phase == 0) hold_off = 200;
      for (int i = 0; i < 215; i++)
        send_angles({pick_angle(), pick_angle(), pick_angle()});
    end
    in_tvalid <= 1'b0;
    while (quat_sb.pending_quats.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d angle triples over both directions and four idle mixes;",
             beats_in);
    $display("checked %0d quaternions, %0d mismatches.", quat_sb.checked, quat_sb.errors);
    if (quat_sb.errors == 0 && quat_sb.pending_quats.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/euq_pkg.sv
sv/euq_prep.sv
sv/euq_cordic_cell.sv
sv/euq_combine.sv
sv/euler_to_quaternion.sv
sv/euq_checker.sv
verif/tb_top.sv
